// ----- design/pcf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants for the PCM channel to float32 converter.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int MAX_CHANNELS    = 32;
    localparam int MAX_FRAME_BYTES = 128;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);

    localparam logic [7:0] EXP_BIAS = 8'd127;

    // Status codes of a result.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NONFINITE = 2'd1;
    localparam logic [1:0] STATUS_CHANNEL   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SAMPLE_FORMAT  = 3'd0;
    localparam logic [2:0] REG_SAMPLE_BYTES   = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT  = 3'd2;
    localparam logic [2:0] REG_CHANNEL_SELECT = 3'd3;
    localparam logic [2:0] REG_FRAME_COUNT    = 3'd4;

    // Scale exponents 8*N-1 for 16 and 24 bit samples; 32-bit samples use 31.
    localparam logic [4:0] SCALE_16 = 5'd15;
    localparam logic [4:0] SCALE_24 = 5'd23;

    // A gathered sample on its way from the frame tracker to the converter.
    typedef struct packed {
        logic [31:0] raw;
        logic [4:0]  scale;
        logic        is_float;
        logic [1:0]  status;
        logic        last;
    } req_t;

endpackage

// ----- design/pcf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_front
// Configuration registers, frame byte tracking and sample gathering.
// ----------------------------------------------------------------------------
module pcf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    output logic                req_valid,
    input  logic                req_ready,
    output pcf_pkg::req_t       req
);

    logic                         sample_format_reg;
    logic [2:0]                   sample_bytes_reg;
    logic [5:0]                   channel_count_reg;
    logic [4:0]                   channel_select_reg;
    logic [31:0]                  frame_count_reg;

    logic [pcf_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [31:0]                  gather_reg, gather_next;
    logic [31:0]                  frames_done_reg, frames_done_next;
    logic                         error_latched_reg, error_latched_next;
    logic                         req_valid_reg, req_valid_next;
    pcf_pkg::req_t                req_reg, req_next;

    logic [2:0]                   sb_eff;
    logic [5:0]                   cc_eff;
    logic [8:0]                   frame_bytes;
    logic [8:0]                   lane_off;
    logic [8:0]                   pos_ext;
    logic [8:0]                   lane_rel;
    logic                         chan_ok;
    logic                         active;
    logic                         accept;
    logic                         in_lane;
    logic                         frame_end;
    logic [31:0]                  gather_upd;
    logic                         nonfinite;

    assign in_stall  = req_valid_reg && !req_ready;
    assign accept    = in_valid && !in_stall;
    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    always_comb
    begin
        if (sample_format_reg)
            sb_eff = 3'd4;
        else if (sample_bytes_reg < 3'd2)
            sb_eff = 3'd2;
        else if (sample_bytes_reg > 3'd4)
            sb_eff = 3'd4;
        else
            sb_eff = sample_bytes_reg;

        if (channel_count_reg == 6'd0)
            cc_eff = 6'd1;
        else if (channel_count_reg > 6'(pcf_pkg::MAX_CHANNELS))
            cc_eff = 6'(pcf_pkg::MAX_CHANNELS);
        else
            cc_eff = channel_count_reg;

        frame_bytes = 9'(cc_eff) * 9'(sb_eff);
        lane_off    = 9'(channel_select_reg) * 9'(sb_eff);
        chan_ok     = {1'b0, channel_select_reg} < cc_eff;
        active      = frames_done_reg < frame_count_reg;
        pos_ext     = 9'(pos_reg);
        lane_rel    = pos_ext - lane_off;
        in_lane     = chan_ok && (pos_ext >= lane_off) && (pos_ext < lane_off + 9'(sb_eff));
        gather_upd  = gather_reg;
        if (in_lane)
            gather_upd = gather_reg | (32'(data_byte) << {lane_rel[1:0], 3'b000});
        frame_end   = (pos_ext + 9'd1) >= frame_bytes;
        nonfinite   = sample_format_reg && (gather_upd[30:23] == 8'hFF);

        pos_next           = pos_reg;
        gather_next        = gather_reg;
        frames_done_next   = frames_done_reg;
        error_latched_next = error_latched_reg;
        req_valid_next     = req_valid_reg && !req_ready;
        req_next           = req_reg;

        if (accept && active)
        begin
            if (frame_end)
            begin
                pos_next          = '0;
                gather_next       = '0;
                frames_done_next  = frames_done_reg + 32'd1;
                req_valid_next    = 1'b1;
                req_next.raw      = gather_upd;
                req_next.scale    = 5'({sb_eff, 3'b000} - 6'd1);
                req_next.is_float = sample_format_reg;
                req_next.last     = (frames_done_reg + 32'd1) == frame_count_reg;
                if (!chan_ok)
                    req_next.status = pcf_pkg::STATUS_CHANNEL;
                else if (error_latched_reg || nonfinite)
                begin
                    req_next.status    = pcf_pkg::STATUS_NONFINITE;
                    error_latched_next = 1'b1;
                end
                else
                    req_next.status = pcf_pkg::STATUS_OK;
            end
            else
            begin
                pos_next    = pcf_pkg::POS_W'(pos_ext + 9'd1);
                gather_next = gather_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_format_reg  <= 1'b0;
            sample_bytes_reg   <= 3'd2;
            channel_count_reg  <= 6'd1;
            channel_select_reg <= 5'd0;
            frame_count_reg    <= 32'd0;
            pos_reg            <= '0;
            gather_reg         <= '0;
            frames_done_reg    <= '0;
            error_latched_reg  <= 1'b0;
            req_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pcf_pkg::REG_SAMPLE_FORMAT:  sample_format_reg  <= cfg_data[0];
                    pcf_pkg::REG_SAMPLE_BYTES:   sample_bytes_reg   <= cfg_data[2:0];
                    pcf_pkg::REG_CHANNEL_COUNT:  channel_count_reg  <= cfg_data[5:0];
                    pcf_pkg::REG_CHANNEL_SELECT: channel_select_reg <= cfg_data[4:0];
                    pcf_pkg::REG_FRAME_COUNT:    frame_count_reg    <= cfg_data;
                    default: ;
                endcase
            end
            pos_reg           <= pos_next;
            gather_reg        <= gather_next;
            frames_done_reg   <= frames_done_next;
            error_latched_reg <= error_latched_next;
            req_valid_reg     <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

`ifndef NO_ASSERTIONS
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_latched_reg |=> error_latched_reg)
        else $error("latched error cleared without reset");

    a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !req_ready |=> req_valid_reg && $stable(req_reg))
        else $error("pending sample lost or changed while stalled");

    a_nonfinite_latched: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && (req_reg.status == pcf_pkg::STATUS_NONFINITE)
            |-> error_latched_reg)
        else $error("non-finite status sent without the error latched");
`endif

endmodule

// ----- design/pcf_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_conv
// Three-stage integer to IEEE single converter with float pass-through.
// ----------------------------------------------------------------------------
module pcf_conv (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  pcf_pkg::req_t req,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [31:0]   sample_float,
    output logic [1:0]    status,
    output logic          last
);

    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
        logic [4:0]  scale;
        logic        is_float;
        logic [1:0]  status;
        logic        last;
    } stage_t;

    logic        b_valid_reg, c_valid_reg, d_valid_reg;
    stage_t      b_reg, b_next, c_reg;
    logic [4:0]  c_lead_reg, c_lead_next;
    logic        c_zero_reg, c_zero_next;
    logic [31:0] d_sample_reg, d_sample_next;
    logic [1:0]  d_status_reg;
    logic        d_last_reg;

    logic        ready_b, ready_c, ready_d;
    logic [31:0] sx;
    logic [31:0] norm;
    logic [23:0] mant_r;
    logic        round_up;
    logic [7:0]  exp_v;

    assign ready_d   = !d_valid_reg || !out_stall;
    assign ready_c   = !c_valid_reg || ready_d;
    assign ready_b   = !b_valid_reg || ready_c;
    assign req_ready = ready_b;

    // Stage B: sign extension and magnitude.
    always_comb
    begin
        case (req.scale)
            pcf_pkg::SCALE_16: sx = {{16{req.raw[15]}}, req.raw[15:0]};
            pcf_pkg::SCALE_24: sx = {{8{req.raw[23]}}, req.raw[23:0]};
            default:           sx = req.raw;
        endcase
        b_next.neg      = sx[31] && !req.is_float;
        b_next.mag      = req.is_float ? req.raw : (sx[31] ? (~sx + 32'd1) : sx);
        b_next.scale    = req.scale;
        b_next.is_float = req.is_float;
        b_next.status   = req.status;
        b_next.last     = req.last;
    end

    // Stage C: leading one search.
    always_comb
    begin
        c_lead_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (b_reg.mag[i])
                c_lead_next = 5'(i);
        end
        c_zero_next = b_reg.mag == 32'd0;
    end

    // Stage D: normalise, round to nearest even and pack; floats pass.
    always_comb
    begin
        norm     = c_reg.mag << (5'd31 - c_lead_reg);
        round_up = norm[7] && ((|norm[6:0]) || norm[8]);
        mant_r   = {1'b0, norm[30:8]} + 24'(round_up);
        exp_v    = 8'(c_lead_reg) + pcf_pkg::EXP_BIAS - 8'(c_reg.scale) + 8'(mant_r[23]);
        if (c_reg.status != pcf_pkg::STATUS_OK)
            d_sample_next = '0;
        else if (c_reg.is_float)
            d_sample_next = c_reg.mag;
        else if (c_zero_reg)
            d_sample_next = '0;
        else
            d_sample_next = {c_reg.neg, exp_v, mant_r[22:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_b)
                b_valid_reg <= req_valid;
            if (ready_c)
                c_valid_reg <= b_valid_reg;
            if (ready_d)
                d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_b)
            b_reg <= b_next;
        if (ready_c)
        begin
            c_reg      <= b_reg;
            c_lead_reg <= c_lead_next;
            c_zero_reg <= c_zero_next;
        end
        if (ready_d)
        begin
            d_sample_reg <= d_sample_next;
            d_status_reg <= c_reg.status;
            d_last_reg   <= c_reg.last;
        end
    end

    assign out_valid    = d_valid_reg;
    assign sample_float = d_sample_reg;
    assign status       = d_status_reg;
    assign last         = d_last_reg;

`ifndef NO_ASSERTIONS
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && (d_status_reg != pcf_pkg::STATUS_OK) |-> d_sample_reg == 32'd0)
        else $error("error result carries a non-zero sample");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && out_stall |=> d_valid_reg && $stable(d_sample_reg))
        else $error("stalled result changed");

    a_out_tags_held: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && out_stall |=> $stable(d_status_reg) && $stable(d_last_reg))
        else $error("stalled status or last flag changed");
`endif

endmodule

// ----- design/pcm_channel_to_float32_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_channel_to_float32_top
// Extracts one channel of an interleaved WAV data chunk as IEEE singles.
// ----------------------------------------------------------------------------
// The block takes one data-chunk byte per cycle and never holds the input
// back unless a finished sample is waiting behind a stalled output. The
// frame tracker updates its byte position and gathered bytes in the cycle a
// byte is accepted; on the last byte of a frame it hands the sample to a
// three-stage converter (magnitude, leading one search, normalise and
// round), so a result passes through the request register and the stage
// registers B, C and D before it is presented on the output.
// Throughput is one byte per cycle, set by the frame tracker, unless stalled.
// Configuration is written through a simple write port; the user must write
// it only while the block is idle, which the block does not enforce. Writes
// to indexes beyond the frame count register are ignored. Status 2 flags a
// channel outside the channel count, and status 1 flags a non-finite float
// sample and stays set for every later in-range transaction until reset.
// Bytes after the configured number of frames are accepted and dropped.
module pcm_channel_to_float32_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample_float,
    output logic [1:0]  status,
    output logic        last
);

    // Gathered samples pass from the tracker to the converter as one struct.
    logic          req_valid;
    logic          req_ready;
    pcf_pkg::req_t req;

    pcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    pcf_conv u_conv (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_float (sample_float),
        .status       (status),
        .last         (last)
    );

endmodule

// ----- bench/tb_pcm_channel_to_float32_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcm_channel_to_float32_top
// Self-checking bench for the PCM channel to float32 converter.
// ----------------------------------------------------------------------------
// A driver feeds data-chunk bytes from a queue that the stimulus process
// fills, and a monitor compares every output transaction with the sample
// that the bench's own converter model predicted for the accepted bytes.
// Configuration is rewritten between phases, only once the block has gone
// quiet. A short directed part covers the integer extremes, odd register
// values, channels out of range, the end of the stream and a change of
// frame size mid-frame; a long random part follows, and the sticky
// non-finite float case runs last because only reset would clear it.
module tb_pcm_channel_to_float32_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [31:0] sample_float;
        logic [1:0]  status;
        logic        last;
    } sample_exp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] sample_float;
    logic [1:0]  status;
    logic        last;

    pcm_channel_to_float32_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_float (sample_float),
        .status       (status),
        .last         (last)
    );

    // Bytes waiting to be driven, and samples waiting to be seen.
    logic [7:0]  byte_q[$];
    sample_exp_t sample_q[$];

    // Shadow copy of the registers and the frame tracker.
    logic        m_format;
    logic [2:0]  m_bytes;
    logic [5:0]  m_chans;
    logic [4:0]  m_select;
    logic [31:0] m_frames;
    logic [6:0]  m_pos;
    logic [31:0] m_gather;
    logic [31:0] m_done;
    logic        m_err;

    int unsigned cycles;
    int unsigned fail_count;
    int unsigned checked;
    int unsigned phases;
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          hold_input;
    bit          taken;

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int unsigned eff_bytes(logic fmt, logic [2:0] sb);
        if (fmt)
            return 4;
        if (sb < 3'd2)
            return 2;
        if (sb > 3'd4)
            return 4;
        return sb;
    endfunction

    function automatic int unsigned eff_chans(logic [5:0] cc);
        if (cc == 6'd0)
            return 1;
        if (cc > pcf_pkg::MAX_CHANNELS)
            return pcf_pkg::MAX_CHANNELS;
        return cc;
    endfunction

    // Signed integer of nb bytes, scaled by 2^-(8*nb-1), rounded to nearest
    // even where the magnitude has more than 24 significant bits.
    function automatic logic [31:0] pcm_to_single(logic [31:0] raw, int unsigned nb);
        int unsigned width;
        int unsigned scale;
        int unsigned p;
        int unsigned r;
        logic [31:0] mask;
        logic [31:0] v;
        logic [31:0] mag;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] q;
        logic [31:0] bexp;
        logic        neg;
        width = nb * 8;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        scale = width - 1;
        v = raw & mask;
        neg = v[scale];
        mag = neg ? ((~v + 32'd1) & mask) : v;
        if (mag == 32'd0)
            return 32'd0;
        p = 31;
        while (!mag[p])
            p--;
        bexp = p + 127 - scale;
        if (p <= 23)
        begin
            q = mag << (23 - p);
        end
        else
        begin
            r = p - 23;
            rem = mag & ((32'd1 << r) - 32'd1);
            half = 32'd1 << (r - 1);
            q = mag >> r;
            if (rem > half || (rem == half && q[0]))
                q++;
            if (q == 32'h0100_0000)
            begin
                q = q >> 1;
                bexp++;
            end
        end
        return {neg, bexp[7:0], q[22:0]};
    endfunction

    // Advance the frame tracker by one accepted byte and queue any sample.
    task automatic track_byte(logic [7:0] b);
        int unsigned sb;
        int unsigned cc;
        int unsigned fb;
        int unsigned off;
        int unsigned pos;
        bit          chan_ok;
        sample_exp_t e;
        if (m_done >= m_frames)
            return;
        sb = eff_bytes(m_format, m_bytes);
        cc = eff_chans(m_chans);
        fb = cc * sb;
        off = m_select * sb;
        chan_ok = m_select < cc;
        pos = m_pos;
        if (chan_ok && pos >= off && pos < off + sb)
            m_gather = m_gather | ({24'd0, b} << ((pos - off) * 8));
        if (pos + 1 < fb)
        begin
            m_pos = 7'(pos + 1);
            return;
        end
        m_done++;
        e.sample_float = 32'd0;
        e.status = pcf_pkg::STATUS_OK;
        if (!chan_ok)
        begin
            e.status = pcf_pkg::STATUS_CHANNEL;
        end
        else if (m_err)
        begin
            e.status = pcf_pkg::STATUS_NONFINITE;
        end
        else if (m_format)
        begin
            if (m_gather[30:23] == 8'hFF)
            begin
                m_err = 1'b1;
                e.status = pcf_pkg::STATUS_NONFINITE;
            end
            else
            begin
                e.sample_float = m_gather;
            end
        end
        else
        begin
            e.sample_float = pcm_to_single(m_gather, sb);
        end
        e.last = (m_done == m_frames);
        sample_q.push_back(e);
        m_pos = 7'd0;
        m_gather = 32'd0;
    endtask

    // Accepted transactions on both channels, and the cycle limit.
    always @(posedge clk)
    begin
        sample_exp_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** pcm_channel_to_float32_top: FAILED **");
            $finish;
        end
        taken = in_valid && !in_stall;
        if (taken)
            track_byte(data_byte);
        if (out_valid && !out_stall)
        begin
            if (sample_q.size() == 0)
            begin
                $error("unexpected output transaction: sample_float %h status %0d last %0d",
                       sample_float, status, last);
                fail_count++;
            end
            else
            begin
                e = sample_q.pop_front();
                checked++;
                if (sample_float !== e.sample_float)
                begin
                    $error("sample_float: expected %h, actual %h", e.sample_float, sample_float);
                    fail_count++;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, status);
                    fail_count++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, actual %0d", e.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Driver: a byte stays on the port until it has been taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'd0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (!in_valid || taken)
            begin
                if (byte_q.size() != 0 && !hold_input
                    && $urandom_range(99) >= gap_pct)
                begin
                    data_byte <= byte_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Returns once every queued byte is in and every sample has come out.
    task automatic wait_quiet();
        while (byte_q.size() != 0 || in_valid || sample_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            pcf_pkg::REG_SAMPLE_FORMAT:  m_format = value[0];
            pcf_pkg::REG_SAMPLE_BYTES:   m_bytes = value[2:0];
            pcf_pkg::REG_CHANNEL_COUNT:  m_chans = value[5:0];
            pcf_pkg::REG_CHANNEL_SELECT: m_select = value[4:0];
            pcf_pkg::REG_FRAME_COUNT:    m_frames = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Sets up a whole phase; frames counts onward from the frames already done.
    task automatic set_phase(logic fmt, logic [2:0] sb, logic [5:0] cc, logic [4:0] sel,
                             logic [31:0] frames);
        wait_quiet();
        phases++;
        write_reg(pcf_pkg::REG_SAMPLE_FORMAT, {31'd0, fmt});
        write_reg(pcf_pkg::REG_SAMPLE_BYTES, {29'd0, sb});
        write_reg(pcf_pkg::REG_CHANNEL_COUNT, {26'd0, cc});
        write_reg(pcf_pkg::REG_CHANNEL_SELECT, {27'd0, sel});
        write_reg(pcf_pkg::REG_FRAME_COUNT, frames);
    endtask

    // Pushes one sample little-endian, n bytes wide.
    task automatic push_sample(logic [31:0] value, int unsigned n);
        for (int i = 0; i < n; i++)
            byte_q.push_back(value[8*i +: 8]);
    endtask

    task automatic set_idling(int unsigned mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 47; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 47; end
            default: begin gap_pct = 15; stall_pct = 15; end
        endcase
    endtask

    initial
    begin
        int unsigned rand_items;
        int unsigned nfr;
        int unsigned fb;
        int unsigned nbytes;
        logic        fmt;
        logic [2:0]  sb;
        logic [5:0]  cc;
        logic [4:0]  sel;
        logic [31:0] frames;
        logic [7:0]  b;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = pcf_pkg::REG_SAMPLE_FORMAT;
        cfg_data = 32'd0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        out_stall = 1'b0;
        hold_input = 1'b0;
        taken = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        cycles = 0;
        fail_count = 0;
        checked = 0;
        phases = 0;
        m_format = 1'b0;
        m_bytes = 3'd2;
        m_chans = 6'd1;
        m_select = 5'd0;
        m_frames = 32'd0;
        m_pos = 7'd0;
        m_gather = 32'd0;
        m_done = 32'd0;
        m_err = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // With the reset frame count of zero every byte is dropped.
        push_sample(32'h0000_7FFF, 2);

        // 16-bit extremes on the second of two channels.
        set_phase(1'b0, 3'd2, 6'd2, 5'd1, m_done + 4);
        push_sample(32'h8000_1234, 4);
        push_sample(32'h7FFF_FFFF, 4);
        push_sample(32'h0000_8000, 4);
        push_sample(32'h0001_00FF, 4);

        // 24-bit and 32-bit extremes, including a rounding carry.
        set_phase(1'b0, 3'd3, 6'd1, 5'd0, m_done + 3);
        push_sample(32'h0080_0000, 3);
        push_sample(32'h007F_FFFF, 3);
        push_sample(32'h00FF_FFFF, 3);
        set_phase(1'b0, 3'd4, 6'd1, 5'd0, m_done + 4);
        push_sample(32'h8000_0000, 4);
        push_sample(32'h7FFF_FFFF, 4);
        push_sample(32'h0100_0080, 4);
        push_sample(32'h8000_0001, 4);

        // Sample size 0 acts as 2, channel count 0 acts as 1; the extra
        // bytes after the final frame are dropped.
        set_phase(1'b0, 3'd0, 6'd0, 5'd0, m_done + 1);
        push_sample(32'hFFFF_0000, 4);

        // Selected channel beyond the channel count gives status 2.
        set_phase(1'b0, 3'd7, 6'd1, 5'd3, m_done + 2);
        push_sample(32'h5A5A_A5A5, 4);
        push_sample(32'h0F0F_F0F0, 4);

        // Frame size shrinks mid-frame: the next byte closes the frame.
        set_phase(1'b0, 3'd2, 6'd2, 5'd0, m_done + 3);
        push_sample(32'h00C0_4000, 3);
        wait_quiet();
        write_reg(pcf_pkg::REG_CHANNEL_COUNT, 32'd1);
        push_sample(32'h0000_0011, 1);
        while (byte_q.size() != 0 || in_valid)
            @(posedge clk);
        // Sender holds the next frame back until every expected sample has
        // been seen.
        hold_input = 1'b1;
        push_sample(32'h0000_8001, 2);
        while (sample_q.size() != 0)
            @(posedge clk);
        hold_input = 1'b0;
        wait_quiet();

        // Random phases with random register values, extremes included.
        rand_items = 0;
        while (rand_items < 1700)
        begin
            fmt = ($urandom_range(99) < 20);
            sb = 3'($urandom_range(7));
            case ($urandom_range(9))
                0: cc = 6'($urandom_range(63));
                1: cc = ($urandom_range(1)) ? 6'd32 : 6'd63;
                default: cc = 6'($urandom_range(1, 4));
            endcase
            if ($urandom_range(99) < 15)
                sel = 5'($urandom_range(31));
            else
                sel = 5'($urandom_range(eff_chans(cc) - 1));
            fb = eff_chans(cc) * eff_bytes(fmt, sb);
            nfr = 256 / fb;
            if (nfr > 12)
                nfr = 12;
            nfr = $urandom_range(1, nfr);
            case ($urandom_range(19))
                0: frames = 32'd0;
                1: frames = 32'hFFFF_FFFF;
                default: frames = m_done + nfr;
            endcase
            set_phase(fmt, sb, cc, sel, frames);
            set_idling(phases);
            nbytes = nfr * fb + (($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0);
            for (int i = 0; i < nbytes; i++)
            begin
                b = 8'($urandom);
                // Keep floats finite here, as the error would stick until reset.
                if (fmt)
                    b[6] = 1'b0;
                byte_q.push_back(b);
            end
            if (frames != 32'd0)
                rand_items += nbytes;
        end

        // Floats last: finite values, then Inf and NaN, the sticky error, and
        // the out-of-range channel taking precedence over it.
        set_phase(1'b1, 3'd2, 6'd1, 5'd0, m_done + 6);
        set_idling(3);
        push_sample(32'h3F80_0000, 4);
        push_sample(32'hFF7F_FFFF, 4);
        push_sample(32'h7F80_0000, 4);
        push_sample(32'h3F00_0000, 4);
        push_sample(32'hFFC0_0001, 4);
        push_sample(32'h0000_0001, 4);
        set_phase(1'b1, 3'd4, 6'd1, 5'd1, m_done + 2);
        push_sample(32'h4000_0000, 4);
        push_sample(32'h4000_0000, 4);
        wait_quiet();

        $display("Checked %0d samples over %0d configuration phases,", checked, phases);
        $display("with random idling and stalls.");
        if (fail_count == 0)
            $display("** pcm_channel_to_float32_top: PASSED **");
        else
            $display("** pcm_channel_to_float32_top: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
design/pcf_pkg.sv
design/pcf_front.sv
design/pcf_conv.sv
design/pcm_channel_to_float32_top.sv
bench/tb_pcm_channel_to_float32_top.sv
